// ===== rtl/core/u8u2_pkg.sv =====
// Shared types, constants and a helper function for the UTF-8 to UCS-2 decoder.
// Depends on nothing; used by u8u2_step and utf8_to_ucs2_decoder_top.
package u8u2_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 16;
    localparam int PEND_W = 3;
    localparam int LONES_W = 4;

    // Code unit given in place of a sequence that is four or more bytes long.
    localparam logic [CODE_W-1:0] SUBST_CODE = 16'h2020;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic [CODE_W-1:0] partial;
        logic              skip;
    } t_dec_state;

    // What one byte produces on the result side.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              repl;
    } t_dec_result;

    // Count of leading one bits of a byte, 0 to 8.
    function automatic logic [LONES_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [LONES_W-1:0] cnt;
        logic               run;
        cnt = '0;
        run = 1'b1;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (run && b[i]) begin
                cnt = cnt + LONES_W'(1);
            end else begin
                run = 1'b0;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/u8u2_step.sv =====
// Combinational per-byte decode step: next decoder state and optional result.
// Depends on u8u2_pkg.
module u8u2_step (
    input  u8u2_pkg::t_dec_state        i_state,
    input  logic [u8u2_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    output u8u2_pkg::t_dec_state        o_state,
    output u8u2_pkg::t_dec_result       o_result
);
    import u8u2_pkg::*;

    logic [LONES_W-1:0] lones;
    logic [CODE_W-1:0]  shifted;

    assign lones   = lead_ones(i_byte);
    assign shifted = {i_state.partial[CODE_W-7:0], i_byte[5:0]};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_state.skip) begin
            // Discard the tail of an unsupported sequence.
            if (i_state.pend != '0) begin
                o_state.pend = i_state.pend - PEND_W'(1);
            end
            if (o_state.pend == '0) begin
                o_state.skip = 1'b0;
            end
        end else if (i_state.pend != '0) begin
            // Continuation bytes are not checked; their low six bits are taken.
            o_state.partial = shifted;
            o_state.pend    = i_state.pend - PEND_W'(1);
            if (o_state.pend == '0) begin
                o_result.valid  = 1'b1;
                o_result.code   = shifted;
                o_state.partial = '0;
            end
        end else begin
            case (lones) inside
                [0:1]: begin
                    // ASCII or a stray continuation byte passes through.
                    o_result.valid = 1'b1;
                    o_result.code  = {{(CODE_W-BYTE_W){1'b0}}, i_byte};
                end
                2: begin
                    o_state.partial = {{(CODE_W-5){1'b0}}, i_byte[4:0]};
                    o_state.pend    = PEND_W'(1);
                end
                3: begin
                    o_state.partial = {{(CODE_W-4){1'b0}}, i_byte[3:0]};
                    o_state.pend    = PEND_W'(2);
                end
                default: begin
                    o_result.valid = 1'b1;
                    o_result.code  = SUBST_CODE;
                    o_result.repl  = 1'b1;
                    o_state.pend   = PEND_W'(lones - LONES_W'(1));
                    o_state.skip   = 1'b1;
                end
            endcase
        end
        // The last byte of a stream drops any open sequence.
        if (i_last) begin
            o_state = '0;
        end
    end

endmodule

// ===== rtl/core/utf8_to_ucs2_decoder_top.sv =====
// Top level of the UTF-8 to UCS-2 decoder: input register, decode step, result register.
// Depends on u8u2_pkg and u8u2_step.
//
//  Channel   | Direction | Word contents (low bit up)          | Sideband
//  s_axis    | in        | tdata[7:0] byte                     | tlast = last byte of stream
//  m_axis    | out       | tdata[15:0] code unit               | tuser = replaced flag
//
// One byte is accepted per clock when the output side keeps up. An accepted byte is
// registered in the input register. While it sits there its decode step runs as short
// combinational logic, and once the result register is free any code unit lands in
// that register, from which it is offered on m_axis. Reset is synchronous and active
// low; it clears the decoder state and both valid flags. A stall on m_axis holds the
// result register and, through the shared advance condition, the input register;
// s_axis stays ready while the input register is empty.
module utf8_to_ucs2_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [u8u2_pkg::BYTE_W-1:0] i_s_axis_tdata,   // [7:0] byte_in
    input  logic                        i_s_axis_tlast,   // last_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [u8u2_pkg::CODE_W-1:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic                        o_m_axis_tuser    // [0] replaced
);
    import u8u2_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Decoder state.
    t_dec_state r_state;
    t_dec_state n_state;
    t_dec_result step_res;

    // Result register.
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_repl;

    logic out_free;
    logic step_fire;
    logic in_ready;

    // The result slot can take a new word if it is empty or being drained now.
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign step_fire = r_in_valid && out_free;
    assign in_ready  = !r_in_valid || out_free;

    u8u2_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= step_res.valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && step_res.valid) begin
            r_out_code <= step_res.code;
            r_out_repl <= step_res.repl;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_code;
    assign o_m_axis_tuser  = r_out_repl;

    // While skipping, at least one byte of the bad sequence is still owed.
    a_skip_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip |-> (r_state.pend != '0))
        else $error("skip mode with nothing left to skip");

    // A normal sequence never owes more than two continuation bytes.
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.skip |-> (r_state.pend <= PEND_W'(2)))
        else $error("pending count out of range outside skip mode");

    // No payload lingers once a sequence is closed.
    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pend == '0) |-> (r_state.partial == '0))
        else $error("partial code left over with no open sequence");

    // A replaced word always carries the substitute code.
    a_subst_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_repl) |-> (r_out_code == SUBST_CODE))
        else $error("replaced flag without substitute code");

    // The last byte of a stream leaves the decoder in its reset state.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && r_in_last) |=> (r_state == '0))
        else $error("state not cleared after last byte");

endmodule

// ===== tb/u8u2_stream_monitor.sv =====
// Stream monitor for the UTF-8 to UCS-2 decoder: predicts code units from accepted bytes
// and compares them with the words leaving the result channel.
// Depends on nothing but the port widths; instantiated by utf8_to_ucs2_decoder_top_tb.
`timescale 1ns / 1ps

module u8u2_stream_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_in
    input  logic        i_s_tlast,   // last_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [15:0] code_unit
    input  logic        i_m_tuser,   // [0] replaced
    output int          o_err_count,
    output int          o_pending,
    output int          o_units_seen,
    output int          o_subst_seen
);

    typedef struct packed {
        logic [15:0] code;
        logic        repl;
    } t_code_unit;

    localparam logic [15:0] SUBST_UNIT = 16'h2020;
    localparam int          MAX_PRINTS = 40;

    t_code_unit  expected_units[$];
    logic [2:0]  dec_pend = '0;
    logic [15:0] dec_partial = '0;
    logic        dec_skip = 1'b0;
    int          err_count = 0;
    int          units_seen = 0;
    int          subst_seen = 0;
    int          pending_units = 0;

    assign o_err_count  = err_count;
    assign o_pending    = pending_units;
    assign o_units_seen = units_seen;
    assign o_subst_seen = subst_seen;

    function automatic int count_lead_ones(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7-n]) begin
            n++;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        err_count++;
    endtask

    // Advances the decoder state by one byte and queues the code unit it yields, if any.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int         n;
        t_code_unit u;
        logic       hit;
        hit = 1'b0;
        u = '0;
        if (dec_skip) begin
            if (dec_pend != 0) begin
                dec_pend = dec_pend - 3'd1;
            end
            if (dec_pend == 0) begin
                dec_skip = 1'b0;
            end
        end else if (dec_pend != 0) begin
            // Continuations are not checked: the low six bits are taken as they are.
            dec_partial = {dec_partial[9:0], b[5:0]};
            dec_pend = dec_pend - 3'd1;
            if (dec_pend == 0) begin
                u.code = dec_partial;
                hit = 1'b1;
                dec_partial = '0;
            end
        end else begin
            n = count_lead_ones(b);
            if (n <= 1) begin
                u.code = {8'h00, b};
                hit = 1'b1;
            end else if (n == 2) begin
                dec_partial = {11'd0, b[4:0]};
                dec_pend = 3'd1;
            end else if (n == 3) begin
                dec_partial = {12'd0, b[3:0]};
                dec_pend = 3'd2;
            end else begin
                u.code = SUBST_UNIT;
                u.repl = 1'b1;
                hit = 1'b1;
                dec_pend = 3'(n - 1);
                dec_skip = 1'b1;
            end
        end
        if (last) begin
            dec_pend = '0;
            dec_partial = '0;
            dec_skip = 1'b0;
        end
        if (hit) begin
            expected_units.push_back(u);
        end
    endtask

    always @(posedge i_clk) begin
        t_code_unit want;
        if (!i_rst_n) begin
            dec_pend = '0;
            dec_partial = '0;
            dec_skip = 1'b0;
            expected_units.delete();
        end else begin
            // The result side is checked first so that a word with nothing waiting is
            // never matched against a byte accepted at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                if (expected_units.size() == 0) begin
                    report_mismatch($sformatf("code unit 0x%04h (replaced %0b) not expected",
                                              i_m_tdata, i_m_tuser));
                end else begin
                    want = expected_units.pop_front();
                    if (i_m_tdata !== want.code) begin
                        report_mismatch($sformatf("code unit 0x%04h, expected 0x%04h",
                                                  i_m_tdata, want.code));
                    end
                    if (i_m_tuser !== want.repl) begin
                        report_mismatch($sformatf("replaced %0b, expected %0b (unit 0x%04h)",
                                                  i_m_tuser, want.repl, want.code));
                    end
                    units_seen++;
                    if (want.repl) begin
                        subst_seen++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast);
            end
        end
        pending_units = expected_units.size();
    end

endmodule

// ===== tb/utf8_to_ucs2_decoder_top_tb.sv =====
// Top of the testbench for utf8_to_ucs2_decoder_top: makes the byte stimulus, the
// receiver back-pressure and the verdict. Depends on u8u2_pkg, the decoder RTL and
// u8u2_stream_monitor, which does all prediction and comparison.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder_top_tb;

    localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest correct run
    localparam int HOLD_LEN     = 300;     // cycles of the long receiver hold-off
    localparam int PHASE_ITEMS  = 360;     // least words sent per idling mix
    localparam int TAIL_CYCLES  = 8;       // time for a word still in flight to show up
    localparam int LAST_PCT     = 3;       // percent chance that a random word carries tlast, outside broken sequences

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic [u8u2_pkg::BYTE_W-1:0] i_s_axis_tdata = '0;
    logic                        i_s_axis_tlast = 1'b0;
    logic                        i_m_axis_tready = 1'b0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [u8u2_pkg::CODE_W-1:0] o_m_axis_tdata;
    logic                        o_m_axis_tuser;

    int err_count;
    int pending_units;
    int units_seen;
    int subst_seen;

    int src_idle_pct = 10;
    int sink_idle_pct = 86;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int counted_items = 0;

    // Directed words, tlast in bit 8: plain and stray-continuation bytes, two- and
    // three-byte sequences with checked and unchecked continuations, a four-byte
    // substitute with its skipped bytes, a lone long lead that ends the stream at once,
    // an eight-ones lead cut short by tlast, and an open three-byte sequence dropped by
    // tlast with a plain byte after it to show the state was cleared.
    logic [8:0] directed_words [25] = '{
        9'h000, 9'h07F, 9'h080, 9'h0BF,
        9'h0C2, 9'h0A9, 9'h0DF, 9'h0FF,
        9'h0E2, 9'h082, 9'h0AC, 9'h0EF, 9'h03F, 9'h0C0,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h1F8,
        9'h0FF, 9'h100, 9'h000,
        9'h0E2, 9'h182, 9'h041
    };

    utf8_to_ucs2_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    u8u2_stream_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .o_err_count  (err_count),
        .o_pending    (pending_units),
        .o_units_seen (units_seen),
        .o_subst_seen (subst_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a run that has not ended by the limit is a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver. Normally tready follows the current idle percentage. A new hold
    // request from the stimulus process starts a long stretch with tready low, counted
    // here, while the sender keeps offering words so that both registers of the block
    // fill and its input stalls.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_LEN;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offers one word and returns at the edge where it is accepted. A random gap with
    // tvalid low may come first; without one, tvalid stays high from the last word.
    task automatic send_word(input logic [7:0] b, input logic last);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < src_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= b;
        i_s_axis_tlast <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        words_sent++;
    endtask

    // Sender pause: stop offering and wait until every predicted code unit has come out.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_units == 0);
    endtask

    // A byte with exactly n leading ones (n = 0 to 8) and random bits below the zero.
    function automatic logic [7:0] make_lead(input int n);
        logic [7:0] r;
        r = 8'($urandom);
        if (n >= 8) begin
            return 8'hFF;
        end
        return ~(8'hFF >> n) | (r & (8'hFF >> (n + 1)));
    endfunction

    // Mostly a proper 10xxxxxx continuation, sometimes any byte at all, since the block
    // takes whatever arrives in a continuation slot.
    function automatic logic [7:0] make_cont();
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(99) < 80) begin
            return {2'b10, r[5:0]};
        end
        return r;
    endfunction

    function automatic logic rand_last();
        return ($urandom_range(99) < LAST_PCT);
    endfunction

    // One random sequence. Most are well formed with random payload; the rest are long
    // leads with their skipped tails, sequences cut short, stray continuations and noise.
    // Skipped bytes of a long sequence are not counted as decoded items.
    task automatic send_random_sequence();
        int kind;
        int n;
        int ncont;
        kind = $urandom_range(99);
        if (kind < 25) begin
            send_word(make_lead(0), rand_last());
            counted_items++;
        end else if (kind < 30) begin
            send_word(make_lead(1), rand_last());
            counted_items++;
        end else if (kind < 75) begin
            n = (kind < 55) ? 2 : 3;
            send_word(make_lead(n), rand_last());
            for (int i = 1; i < n; i++) begin
                send_word(make_cont(), rand_last());
            end
            counted_items += n;
        end else if (kind < 85) begin
            n = $urandom_range(8, 4);
            send_word(make_lead(n), rand_last());
            for (int i = 1; i < n; i++) begin
                send_word(8'($urandom), rand_last());
            end
            counted_items++;
        end else if (kind < 93) begin
            // Broken sequence: fewer continuations than the lead asks for, sometimes
            // ended by tlast so the open sequence is dropped.
            n = $urandom_range(3, 2);
            ncont = $urandom_range(n - 2, 0);
            send_word(make_lead(n), (ncont == 0) && ($urandom_range(1) == 1));
            for (int i = 0; i < ncont; i++) begin
                send_word(make_cont(), (i == ncont - 1) && ($urandom_range(1) == 1));
            end
            counted_items += 1 + ncont;
        end else begin
            send_word(8'($urandom), rand_last());
            counted_items++;
        end
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct);
        int stop_at;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = words_sent + PHASE_ITEMS;
        while (words_sent < stop_at) begin
            send_random_sequence();
        end
        drain_results();
    endtask

    initial begin
        // Reset is held at the start with all inputs at known values.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i][7:0], directed_words[i][8]);
        end
        drain_results();

        // First random mix: slow receiver, with one long hold-off at its start.
        hold_req <= hold_req + 1;
        run_random_phase(10, 86);
        // Second mix: slow sender, eager receiver.
        run_random_phase(86, 10);
        // Third mix: both sides at full rate.
        run_random_phase(0, 0);

        // Give any word still in flight time to show up as an unexpected result.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (%0d counted items) under three idle mixes and a long stall.",
                 words_sent, counted_items);
        $display("Checked %0d code units, %0d of them substitutes; %0d mismatches.",
                 units_seen, subst_seen, err_count);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
